/* hdl/akd_pkg.sv */
// Package for the analog ladder keypad decoder: widths, reset levels,
// request and register codes, key bit numbers and the shared struct types.
// No dependencies; every other file of the block takes names from here.
`default_nettype none

package akd_pkg;

  // Field and storage widths
  localparam int NumKeys     = 12;
  localparam int AdcBits     = 12;
  localparam int TimerBits   = 24;
  localparam int ElapsedBits = 16;
  localparam int KeyIdxBits  = 4;
  localparam int ReqBits     = 2;
  localparam int CfgIdxBits  = 2;
  localparam int CfgBits     = 12;

  // Threshold register reset values
  localparam logic [AdcBits-1:0] LevelTopRst   = AdcBits'(3500);
  localparam logic [AdcBits-1:0] LevelUpperRst = AdcBits'(2300);
  localparam logic [AdcBits-1:0] LevelFnMidRst = AdcBits'(1800);
  localparam logic [AdcBits-1:0] LevelFloorRst = AdcBits'(500);

  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  // Request codes
  typedef enum logic [ReqBits-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_PRESS  = 2'd1,
    REQ_HOLD   = 2'd2
  } req_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_LEVEL_TOP    = 2'd0,
    CFG_LEVEL_UPPER  = 2'd1,
    CFG_LEVEL_FN_MID = 2'd2,
    CFG_LEVEL_FLOOR  = 2'd3
  } cfg_idx_e;

  // Bit numbers of the keys in the masks
  localparam int KeyA       = 0;
  localparam int KeyB       = 1;
  localparam int KeyC       = 2;
  localparam int KeyD       = 3;
  localparam int KeyLeft    = 4;
  localparam int KeyRight   = 5;
  localparam int KeyUp      = 6;
  localparam int KeyDown    = 7;
  localparam int KeyCenter  = 8;
  localparam int KeyZUp     = 9;
  localparam int KeyZDown   = 10;
  localparam int KeyZCenter = 11;

  // Threshold set handed from the register file to the engine
  typedef struct packed {
    logic [AdcBits-1:0] top;
    logic [AdcBits-1:0] upper;
    logic [AdcBits-1:0] fn_mid;
    logic [AdcBits-1:0] floor_lv;
  } levels_t;

  // One input word
  typedef struct packed {
    logic [ReqBits-1:0]     req_type;
    logic [AdcBits-1:0]     fn_level;
    logic [AdcBits-1:0]     x_level;
    logic [AdcBits-1:0]     y_level;
    logic [AdcBits-1:0]     z_level;
    logic [ElapsedBits-1:0] elapsed_ms;
    logic [KeyIdxBits-1:0]  key_index;
  } item_t;

  // One result word
  typedef struct packed {
    logic                 pressed;
    logic [TimerBits-1:0] hold_ms;
    logic [NumKeys-1:0]   down_mask_out;
    logic                 any_down;
  } result_t;

endpackage

`default_nettype wire

/* hdl/akd_in_if.sv */
// Input channel of the keypad decoder: valid, ready and the request word.
// Depends on akd_pkg for the field widths.
`default_nettype none

interface akd_in_if;
  logic                             valid;
  logic                             ready;
  logic [akd_pkg::ReqBits-1:0]      req_type;
  logic [akd_pkg::AdcBits-1:0]      fn_level;
  logic [akd_pkg::AdcBits-1:0]      x_level;
  logic [akd_pkg::AdcBits-1:0]      y_level;
  logic [akd_pkg::AdcBits-1:0]      z_level;
  logic [akd_pkg::ElapsedBits-1:0]  elapsed_ms;
  logic [akd_pkg::KeyIdxBits-1:0]   key_index;

  modport source (
    output valid, req_type, fn_level, x_level, y_level, z_level, elapsed_ms, key_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, fn_level, x_level, y_level, z_level, elapsed_ms, key_index,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/akd_out_if.sv */
// Output channel of the keypad decoder: valid, ready and the result word.
// Depends on akd_pkg for the field widths.
`default_nettype none

interface akd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             pressed;
  logic [akd_pkg::TimerBits-1:0]    hold_ms;
  logic [akd_pkg::NumKeys-1:0]      down_mask_out;
  logic                             any_down;

  modport source (
    output valid, pressed, hold_ms, down_mask_out, any_down,
    input  ready
  );
  modport sink (
    input  valid, pressed, hold_ms, down_mask_out, any_down,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/akd_cfg_regs.sv */
// Threshold register file of the keypad decoder, written through a plain
// write port. Depends on akd_pkg for widths, indexes and reset values.
`default_nettype none

module akd_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [akd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [akd_pkg::CfgBits-1:0]     cfg_data_i,
  output akd_pkg::levels_t                     levels_o
);

  akd_pkg::levels_t levels_q;

  // Write the addressed threshold; the data is exactly one level wide.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q.top      <= akd_pkg::LevelTopRst;
      levels_q.upper    <= akd_pkg::LevelUpperRst;
      levels_q.fn_mid   <= akd_pkg::LevelFnMidRst;
      levels_q.floor_lv <= akd_pkg::LevelFloorRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        akd_pkg::CFG_LEVEL_TOP:    levels_q.top      <= akd_pkg::AdcBits'(cfg_data_i);
        akd_pkg::CFG_LEVEL_UPPER:  levels_q.upper    <= akd_pkg::AdcBits'(cfg_data_i);
        akd_pkg::CFG_LEVEL_FN_MID: levels_q.fn_mid   <= akd_pkg::AdcBits'(cfg_data_i);
        akd_pkg::CFG_LEVEL_FLOOR:  levels_q.floor_lv <= akd_pkg::AdcBits'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign levels_o = levels_q;

endmodule

`default_nettype wire

/* hdl/akd_engine.sv */
// Key state of the decoder (down mask, acknowledge mask, hold timers) and
// the single-pass logic that turns one request word into its result word.
// Depends on akd_pkg.
`default_nettype none

module akd_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire akd_pkg::item_t    item_i,
  input  wire akd_pkg::levels_t  levels_i,
  output akd_pkg::result_t       result_o
);

  localparam int NK = akd_pkg::NumKeys;
  localparam int TB = akd_pkg::TimerBits;

  logic [NK-1:0] down_q, down_d;
  logic [NK-1:0] ack_q, ack_d;
  logic [TB-1:0] timer_q [NK];
  logic [TB-1:0] timer_d [NK];

  logic [NK-1:0] sample_mask;
  logic [NK-1:0] key_sel;
  logic          hit;
  logic [TB-1:0] hold_sel;
  logic [TB:0]   timer_sum [NK];

  // Ladder comparators: strictly above, highest threshold first.
  always_comb begin
    sample_mask = '0;
    if (item_i.fn_level > levels_i.top)           sample_mask[akd_pkg::KeyD] = 1'b1;
    else if (item_i.fn_level > levels_i.upper)    sample_mask[akd_pkg::KeyC] = 1'b1;
    else if (item_i.fn_level > levels_i.fn_mid)   sample_mask[akd_pkg::KeyB] = 1'b1;
    else if (item_i.fn_level > levels_i.floor_lv) sample_mask[akd_pkg::KeyA] = 1'b1;

    if (item_i.x_level > levels_i.top)            sample_mask[akd_pkg::KeyRight] = 1'b1;
    else if (item_i.x_level > levels_i.floor_lv)  sample_mask[akd_pkg::KeyLeft] = 1'b1;

    if (item_i.y_level > levels_i.top)            sample_mask[akd_pkg::KeyCenter] = 1'b1;
    else if (item_i.y_level > levels_i.upper)     sample_mask[akd_pkg::KeyDown] = 1'b1;
    else if (item_i.y_level > levels_i.floor_lv)  sample_mask[akd_pkg::KeyUp] = 1'b1;

    if (item_i.z_level > levels_i.top)            sample_mask[akd_pkg::KeyZCenter] = 1'b1;
    else if (item_i.z_level > levels_i.upper)     sample_mask[akd_pkg::KeyZDown] = 1'b1;
    else if (item_i.z_level > levels_i.floor_lv)  sample_mask[akd_pkg::KeyZUp] = 1'b1;
  end

  // One-hot key select; an index past the last key shifts out to zero.
  assign key_sel = NK'(1) << item_i.key_index;
  assign hit     = |(down_q & ~ack_q & key_sel);

  // Hold timer read for a hold query.
  always_comb begin
    hold_sel = '0;
    for (int i = 0; i < NK; i++) begin
      if (key_sel[i]) hold_sel = hold_sel | timer_q[i];
    end
  end

  // Saturating timer adders, one per key.
  always_comb begin
    for (int i = 0; i < NK; i++) begin
      timer_sum[i] = {1'b0, timer_q[i]} + (TB + 1)'(item_i.elapsed_ms);
    end
  end

  // Next state and result for the request type.
  always_comb begin
    down_d = down_q;
    ack_d  = ack_q;
    for (int i = 0; i < NK; i++) timer_d[i] = timer_q[i];
    result_o.pressed = 1'b0;
    result_o.hold_ms = '0;
    case (item_i.req_type)
      akd_pkg::REQ_SAMPLE: begin
        down_d = sample_mask;
        ack_d  = ack_q & sample_mask;
        for (int i = 0; i < NK; i++) begin
          if (!sample_mask[i])    timer_d[i] = '0;
          else if (timer_sum[i][TB]) timer_d[i] = akd_pkg::TimerMax;
          else                    timer_d[i] = timer_sum[i][TB-1:0];
        end
      end
      akd_pkg::REQ_PRESS: begin
        if (hit) begin
          down_d = down_q & ~key_sel;
          ack_d  = ack_q | key_sel;
          result_o.pressed = 1'b1;
        end
      end
      akd_pkg::REQ_HOLD: begin
        result_o.hold_ms = hold_sel;
      end
      default: ;
    endcase
    result_o.down_mask_out = down_d;
    result_o.any_down      = |down_d;
  end

  // State advances only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= '0;
      ack_q  <= '0;
      for (int i = 0; i < NK; i++) timer_q[i] <= '0;
    end else if (accept_i) begin
      down_q <= down_d;
      ack_q  <= ack_d;
      for (int i = 0; i < NK; i++) timer_q[i] <= timer_d[i];
    end
  end

endmodule

`default_nettype wire

/* hdl/akd_out_buf.sv */
// Two-entry result buffer: an output register and a skid register, so the
// input side keeps taking words while a result waits. Depends on akd_pkg.
`default_nettype none

module akd_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire akd_pkg::result_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output akd_pkg::result_t      out_data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  akd_pkg::result_t out_data_q;
  akd_pkg::result_t skid_data_q;
  logic             push;
  logic             pop;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  // Control: the skid register only fills while the output register stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push) begin
        if (out_valid_q && !pop) skid_valid_q <= 1'b1;
        else                     out_valid_q  <= 1'b1;
      end else if (pop) begin
        if (skid_valid_q) skid_valid_q <= 1'b0;
        else              out_valid_q  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (push) begin
      if (out_valid_q && !pop) skid_data_q <= in_data_i;
      else                     out_data_q  <= in_data_i;
    end else if (pop && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* hdl/analog_ladder_keypad_decoder_core.sv */
// Analog ladder keypad decoder, top level.
//
// Channels: in_i carries request words (sample, press query, hold query),
// out_o one result word per request, in order. Both use valid and ready; a
// word moves at a rising edge where both are high. Thresholds are written
// via cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while idle (unchecked).
//
// Timing: a result is registered at the edge where its request is taken.
// Throughput: one request per cycle while in_i.ready is high; comparators,
// mask update and twelve saturating timer adders are one level of logic
// ahead of the result register.
//
// Stall: a result register plus a skid register sit on the output; the
// block takes one more request while a result waits and drops in_i.ready
// only once both hold results. No word is lost or repeated.
//
// Reset: thresholds return to their defaults, the down and acknowledge
// masks and all hold timers clear, and both output registers are empty.
// Depends on akd_pkg, akd_in_if, akd_out_if and the akd_* modules.
`default_nettype none

module analog_ladder_keypad_decoder_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [akd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [akd_pkg::CfgBits-1:0]     cfg_data_i,
  akd_in_if.sink                               in_i,
  akd_out_if.source                            out_o
);

  akd_pkg::levels_t levels;
  akd_pkg::item_t   item;
  akd_pkg::result_t result;
  akd_pkg::result_t out_data;
  logic             in_ready;
  logic             accept;

  // Gather the input word.
  assign item.req_type   = in_i.req_type;
  assign item.fn_level   = in_i.fn_level;
  assign item.x_level    = in_i.x_level;
  assign item.y_level    = in_i.y_level;
  assign item.z_level    = in_i.z_level;
  assign item.elapsed_ms = in_i.elapsed_ms;
  assign item.key_index  = in_i.key_index;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  akd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .levels_o   (levels)
  );

  akd_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .levels_i (levels),
    .result_o (result)
  );

  akd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_data_i   (result),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  // Spread the result word onto the output channel.
  assign out_o.pressed       = out_data.pressed;
  assign out_o.hold_ms       = out_data.hold_ms;
  assign out_o.down_mask_out = out_data.down_mask_out;
  assign out_o.any_down      = out_data.any_down;

endmodule

`default_nettype wire
